// File: rtl/lrubp_pkg.sv
// Package for the LRU buffer pool frame manager.
// Holds the sizes, codes, state type and structs that the frame table and
// the top level share. It depends on nothing.
package lrubp_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int PAGE_W     = 32;
    localparam int PIN_W      = 8;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int RANK_W     = IDX_W;
    localparam int LIM_W      = RANK_W + 1;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int FRAMES_RST = 16;

    typedef enum logic [1:0] {
        REQ_FETCH = 2'd0,
        REQ_UNPIN = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_BAD   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_ALL_PINNED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic [PIN_W-1:0]  pins;
        logic              dirty;
        logic [RANK_W-1:0] rank;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           data;
    } t_tbl_wr;

    typedef struct packed {
        t_status           status;
        logic              was_hit;
        logic [IDX_W-1:0]  frame_slot;
        logic              writeback;
        logic [PAGE_W-1:0] writeback_page;
        logic [PIN_W-1:0]  pins_after;
    } t_result;

endpackage

// File: rtl/lrubp_frame_table.sv
// Frame table of the buffer pool: page, pin count, dirty mark and recency
// rank of every frame, with one read index and one write port per cycle.
// Depends on lrubp_pkg.
module lrubp_frame_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [lrubp_pkg::IDX_W-1:0]         i_rd_idx,
    output lrubp_pkg::t_entry                   o_rd,
    input  lrubp_pkg::t_tbl_wr                  i_wr
);
    import lrubp_pkg::*;

    logic [NUM_FRAMES-1:0] r_valid;
    logic [PAGE_W-1:0]     r_page  [NUM_FRAMES];
    logic [PIN_W-1:0]      r_pins  [NUM_FRAMES];
    logic                  r_dirty [NUM_FRAMES];
    logic [RANK_W-1:0]     r_rank  [NUM_FRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= i_wr.data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_page[i_wr.idx]  <= i_wr.data.page;
            r_pins[i_wr.idx]  <= i_wr.data.pins;
            r_dirty[i_wr.idx] <= i_wr.data.dirty;
            r_rank[i_wr.idx]  <= i_wr.data.rank;
        end
    end

    always_comb begin
        o_rd.valid = r_valid[i_rd_idx];
        o_rd.page  = r_page[i_rd_idx];
        o_rd.pins  = r_pins[i_rd_idx];
        o_rd.dirty = r_dirty[i_rd_idx];
        o_rd.rank  = r_rank[i_rd_idx];
    end

endmodule

// File: rtl/lru_buffer_pool_frame_manager.sv
// Top level of the LRU buffer pool frame manager: request sequencer, scan
// and update passes over the frame table, result register and config.
// Depends on lrubp_pkg and lrubp_frame_table.
//
// Requests enter on the slave stream: tuser carries the request type, tdata
// the page number and the dirty mark. Each request gives one result on the
// master stream: tuser carries the status, tdata the remaining fields.
// The config channel writes the frame limit; it is always ready. The user
// must write it only while the block is idle; the block does not enforce it.
// A request is handled by one compare unit that visits one frame per cycle.
// A scan pass finds the page, the first free frame, the valid count and
// the least recent unpinned frame. A fetch that hits or loads a page then
// runs a second pass that rewrites the recency ranks. The block takes one
// request at a time.
// The result register holds a result until the receiver takes it; a new
// request is accepted meanwhile, and its result waits in the sequencer.
// Reset empties the pool and sets the frame limit to 16.
module lru_buffer_pool_frame_manager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrubp_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // Bits from 0: page_number (32), mark_dirty (1), zero fill (7).
    input  logic [39:0]                 i_s_axis_tdata,
    // Bits from 0: req_type (2).
    input  logic [1:0]                  i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // Bits from 0: was_hit (1), frame_slot (4), writeback (1),
    // writeback_page (32), pins_after (8), zero fill (2).
    output logic [47:0]                 o_m_axis_tdata,
    // Bits from 0: status (2).
    output logic [1:0]                  o_m_axis_tuser
);
    import lrubp_pkg::*;

    t_state  r_state, n_state;
    t_entry  rd;
    t_tbl_wr wr;

    logic [CFG_W-1:0]  r_frames_in_use;
    logic [IDX_W-1:0]  r_idx;
    t_req              r_req;
    logic [PAGE_W-1:0] r_page;
    logic              r_mdirty;

    logic              r_hit;
    logic [IDX_W-1:0]  r_hslot;
    logic [RANK_W-1:0] r_hrank;
    logic [PIN_W-1:0]  r_hpins;
    logic              r_hdirty;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free_slot;
    logic              r_vic_found;
    logic [IDX_W-1:0]  r_vslot;
    logic [RANK_W-1:0] r_vrank;
    logic              r_vdirty;
    logic [PAGE_W-1:0] r_vpage;

    logic [IDX_W-1:0]  r_s;
    logic [LIM_W-1:0]  r_lim;
    logic [PIN_W-1:0]  r_tpins;
    logic              r_tdirty;
    t_result           r_res;

    logic              r_o_valid;
    t_result           r_out;

    logic              in_accept;
    logic              last_idx;
    logic              match;
    logic              vic_cand;
    logic [CNT_W-1:0]  limit;
    logic              go_update;
    logic              out_free;
    logic              single_wr;
    logic [IDX_W-1:0]  d_s;
    logic [LIM_W-1:0]  d_lim;
    logic [PIN_W-1:0]  d_tpins;
    logic              d_tdirty;
    t_result           d_res;

    lrubp_frame_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .o_rd     (rd),
        .i_wr     (wr)
    );

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign last_idx    = (r_idx == IDX_W'(NUM_FRAMES - 1));
    assign out_free    = !r_o_valid || i_m_axis_tready;
    assign match       = rd.valid && (rd.page == r_page);
    assign vic_cand    = rd.valid && (rd.pins == '0) &&
                         (!r_vic_found || (rd.rank > r_vrank));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_W'(FRAMES_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_frames_in_use == '0) begin
            limit = CNT_W'(1);
        end else if (int'(r_frames_in_use) > NUM_FRAMES) begin
            limit = CNT_W'(NUM_FRAMES);
        end else begin
            limit = CNT_W'(r_frames_in_use);
        end
    end

    // Decision taken once the scan pass has finished.
    always_comb begin
        d_s       = r_hslot;
        d_lim     = {1'b0, r_hrank};
        d_tpins   = r_hpins;
        d_tdirty  = r_hdirty;
        go_update = 1'b0;
        single_wr = 1'b0;
        d_res     = '0;
        d_res.status = ST_OK;
        unique case (r_req)
            REQ_FETCH: begin
                if (r_hit) begin
                    d_tpins   = (r_hpins == {PIN_W{1'b1}}) ? r_hpins : r_hpins + 1'b1;
                    go_update = 1'b1;
                    d_res.was_hit = 1'b1;
                end else if (r_cnt < limit) begin
                    d_s       = r_free_slot;
                    d_lim     = LIM_W'(NUM_FRAMES);
                    d_tpins   = PIN_W'(1);
                    d_tdirty  = 1'b0;
                    go_update = 1'b1;
                end else if (r_vic_found) begin
                    d_s       = r_vslot;
                    d_lim     = {1'b0, r_vrank} + 1'b1;
                    d_tpins   = PIN_W'(1);
                    d_tdirty  = 1'b0;
                    go_update = 1'b1;
                    d_res.writeback      = r_vdirty;
                    d_res.writeback_page = r_vdirty ? r_vpage : '0;
                end else begin
                    d_res.status = ST_ALL_PINNED;
                end
            end
            REQ_UNPIN: begin
                if (r_hit) begin
                    d_tpins   = (r_hpins == '0) ? r_hpins : r_hpins - 1'b1;
                    d_tdirty  = r_hdirty || r_mdirty;
                    single_wr = 1'b1;
                end else begin
                    d_res.status = ST_NOT_FOUND;
                end
            end
            REQ_FLUSH: begin
                if (r_hit) begin
                    d_tdirty  = 1'b0;
                    single_wr = 1'b1;
                    d_res.writeback      = r_hdirty;
                    d_res.writeback_page = r_hdirty ? r_page : '0;
                end else begin
                    d_res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                d_res.status = ST_NOT_FOUND;
            end
        endcase
        if (d_res.status == ST_OK) begin
            d_res.frame_slot = d_s;
            d_res.pins_after = d_tpins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req    <= t_req'(i_s_axis_tuser);
            r_page   <= i_s_axis_tdata[PAGE_W-1:0];
            r_mdirty <= i_s_axis_tdata[PAGE_W];
            r_hit        <= 1'b0;
            r_cnt        <= '0;
            r_free_found <= 1'b0;
            r_vic_found  <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (match && !r_hit) begin
                r_hit    <= 1'b1;
                r_hslot  <= r_idx;
                r_hrank  <= rd.rank;
                r_hpins  <= rd.pins;
                r_hdirty <= rd.dirty;
            end
            if (rd.valid) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (!rd.valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_idx;
            end
            if (vic_cand) begin
                r_vic_found <= 1'b1;
                r_vslot     <= r_idx;
                r_vrank     <= rd.rank;
                r_vdirty    <= rd.dirty;
                r_vpage     <= rd.page;
            end
        end
        if (r_state == S_DECIDE) begin
            r_s      <= d_s;
            r_lim    <= d_lim;
            r_tpins  <= d_tpins;
            r_tdirty <= d_tdirty;
            r_res    <= d_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCAN || r_state == S_UPDATE) begin
                r_idx <= r_idx + 1'b1;
            end else begin
                r_idx <= '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_accept) n_state = S_SCAN;
            S_SCAN:   if (last_idx) n_state = S_DECIDE;
            S_DECIDE: n_state = go_update ? S_UPDATE : S_OUT;
            S_UPDATE: if (last_idx) n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        wr = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_DECIDE: begin
                wr.en         = single_wr;
                wr.idx        = r_hslot;
                wr.data.valid = 1'b1;
                wr.data.page  = r_page;
                wr.data.pins  = d_tpins;
                wr.data.dirty = d_tdirty;
                wr.data.rank  = r_hrank;
            end
            S_UPDATE: begin
                wr.idx = r_idx;
                if (r_idx == r_s) begin
                    wr.en         = 1'b1;
                    wr.data.valid = 1'b1;
                    wr.data.page  = r_page;
                    wr.data.pins  = r_tpins;
                    wr.data.dirty = r_tdirty;
                    wr.data.rank  = '0;
                end else if (rd.valid && ({1'b0, rd.rank} < r_lim)) begin
                    wr.en        = 1'b1;
                    wr.data      = rd;
                    wr.data.rank = rd.rank + 1'b1;
                end
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {2'b00, r_out.pins_after, r_out.writeback_page,
                              r_out.writeback, r_out.frame_slot, r_out.was_hit};

endmodule

// File: rtl/lrubp_checker.sv
// Port-level checker for the LRU buffer pool frame manager, bound to the
// top level. Depends on lrubp_pkg and on the top level's ports.
module lrubp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import lrubp_pkg::*;

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("Block accepted a request while busy.");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == ST_OK) ||
                             (o_m_axis_tuser == ST_NOT_FOUND) ||
                             (o_m_axis_tuser == ST_ALL_PINNED)))
        else $error("Result carries an undefined status.");

    a_failed_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_OK)) |-> (o_m_axis_tdata == 48'd0))
        else $error("Failed request reports nonzero fields.");

    a_wb_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[5]) |-> (o_m_axis_tdata[37:6] == 32'd0))
        else $error("Writeback page set without writeback.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("Stalled result changed.");

endmodule

bind lru_buffer_pool_frame_manager lrubp_checker u_lrubp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_buffer_pool_frame_manager. A cycle-free model of the
// frame table predicts every reply, and the replies are checked in order. Depends on lrubp_pkg.
module tb;
    import lrubp_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 4000;
    localparam int PAGE_SET_N  = 24;
    localparam logic [PIN_W-1:0] PIN_SAT = {PIN_W{1'b1}};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic [39:0]       s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tready  = 1'b0;
    logic              cfg_ready;
    logic              s_tready;
    logic              m_tvalid;
    logic [47:0]       m_tdata;
    logic [1:0]        m_tuser;

    logic              fr_valid [NUM_FRAMES] = '{default: 1'b0};
    logic [PAGE_W-1:0] fr_page  [NUM_FRAMES] = '{default: '0};
    logic [PIN_W-1:0]  fr_pins  [NUM_FRAMES] = '{default: '0};
    logic              fr_dirty [NUM_FRAMES] = '{default: 1'b0};
    int                fr_rank  [NUM_FRAMES] = '{default: 0};
    logic [CFG_W-1:0]  frame_limit = CFG_W'(FRAMES_RST);

    t_result           pending_replies[$];
    logic [PAGE_W-1:0] page_set [PAGE_SET_N];
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                hold_off    = 0;
    int                mismatches  = 0;
    int                quiet_cycles = 0;

    lru_buffer_pool_frame_manager uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic t_result predict_pool_request(t_req rq, logic [PAGE_W-1:0] pg,
                                                     logic md);
        t_result r;
        int s, victim, used, lim, old;
        r = '0;
        s = -1;
        victim = -1;
        used = 0;
        for (int i = 0; i < NUM_FRAMES; i++)
            if (s < 0 && fr_valid[i] && fr_page[i] == pg)
                s = i;
        case (rq)
            REQ_FETCH: begin
                if (s >= 0) begin
                    old = fr_rank[s];
                    for (int i = 0; i < NUM_FRAMES; i++)
                        if (fr_valid[i] && i != s && fr_rank[i] < old)
                            fr_rank[i]++;
                    fr_rank[s] = 0;
                    if (fr_pins[s] != PIN_SAT)
                        fr_pins[s]++;
                    r.was_hit = 1'b1;
                end else begin
                    lim = int'(frame_limit);
                    if (lim < 1)
                        lim = 1;
                    if (lim > NUM_FRAMES)
                        lim = NUM_FRAMES;
                    for (int i = 0; i < NUM_FRAMES; i++)
                        if (fr_valid[i])
                            used++;
                    if (used < lim) begin
                        for (int i = 0; i < NUM_FRAMES; i++)
                            if (s < 0 && !fr_valid[i])
                                s = i;
                    end else begin
                        for (int i = 0; i < NUM_FRAMES; i++)
                            if (fr_valid[i] && fr_pins[i] == 0 &&
                                (victim < 0 || fr_rank[i] > fr_rank[victim]))
                                victim = i;
                        if (victim >= 0) begin
                            if (fr_dirty[victim]) begin
                                r.writeback = 1'b1;
                                r.writeback_page = fr_page[victim];
                            end
                            old = fr_rank[victim];
                            for (int i = 0; i < NUM_FRAMES; i++)
                                if (fr_valid[i] && i != victim && fr_rank[i] > old)
                                    fr_rank[i]--;
                            fr_valid[victim] = 1'b0;
                            s = victim;
                        end
                    end
                    if (s < 0) begin
                        r.status = ST_ALL_PINNED;
                    end else begin
                        for (int i = 0; i < NUM_FRAMES; i++)
                            if (fr_valid[i])
                                fr_rank[i]++;
                        fr_valid[s] = 1'b1;
                        fr_page[s]  = pg;
                        fr_pins[s]  = PIN_W'(1);
                        fr_dirty[s] = 1'b0;
                        fr_rank[s]  = 0;
                    end
                end
            end
            REQ_UNPIN, REQ_FLUSH: begin
                if (s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (rq == REQ_UNPIN) begin
                    if (fr_pins[s] != 0)
                        fr_pins[s]--;
                    if (md)
                        fr_dirty[s] = 1'b1;
                end else if (fr_dirty[s]) begin
                    fr_dirty[s] = 1'b0;
                    r.writeback = 1'b1;
                    r.writeback_page = pg;
                end
            end
            default: r.status = ST_NOT_FOUND;
        endcase
        if (r.status == ST_OK && s >= 0) begin
            r.frame_slot = IDX_W'(s);
            r.pins_after = fr_pins[s];
        end else begin
            r.was_hit = 1'b0;
            r.writeback = 1'b0;
            r.writeback_page = '0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge clk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin : reply_check
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("reply arrived with no request outstanding");
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check_field("status", 64'(want.status), 64'(m_tuser));
                check_field("was_hit", 64'(want.was_hit), 64'(m_tdata[0]));
                check_field("frame_slot", 64'(want.frame_slot), 64'(m_tdata[4:1]));
                check_field("writeback", 64'(want.writeback), 64'(m_tdata[5]));
                check_field("writeback_page", 64'(want.writeback_page),
                            64'(m_tdata[37:6]));
                check_field("pins_after", 64'(want.pins_after), 64'(m_tdata[45:38]));
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_req(t_req rq, logic [PAGE_W-1:0] pg, logic md);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, md, pg};
        s_tuser  <= rq;
        do @(posedge clk); while (!s_tready);
        pending_replies.push_back(predict_pool_request(rq, pg, md));
    endtask

    task automatic wait_for_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_limit(logic [CFG_W-1:0] lim);
        wait_for_replies();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge clk); while (!cfg_ready);
        frame_limit = lim;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_basic_requests();
        send_req(REQ_UNPIN, 32'h1234_5678, 1'b1);
        send_req(REQ_FLUSH, 32'h1234_5678, 1'b0);
        send_req(REQ_BAD, 32'h0000_0000, 1'b0);
        send_req(REQ_FETCH, 32'h0000_0000, 1'b0);
        send_req(REQ_FETCH, 32'hFFFF_FFFF, 1'b1);
        send_req(REQ_FETCH, 32'h0000_0000, 1'b0);
        send_req(REQ_UNPIN, 32'h0000_0000, 1'b1);
        send_req(REQ_UNPIN, 32'h0000_0000, 1'b0);
        send_req(REQ_UNPIN, 32'h0000_0000, 1'b1);
        send_req(REQ_FLUSH, 32'h0000_0000, 1'b0);
        send_req(REQ_FLUSH, 32'h0000_0000, 1'b0);
        send_req(REQ_FLUSH, 32'hFFFF_FFFF, 1'b0);
        send_req(REQ_BAD, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_frame_limits();
        write_frame_limit(5'd0);
        send_req(REQ_FETCH, 32'hA5A5_A5A5, 1'b0);
        send_req(REQ_FETCH, 32'h5A5A_5A5A, 1'b0);
        send_req(REQ_UNPIN, 32'hA5A5_A5A5, 1'b1);
        send_req(REQ_FETCH, 32'h5A5A_5A5A, 1'b0);
        write_frame_limit(5'd31);
        send_req(REQ_FETCH, 32'h8000_0000, 1'b0);
        send_req(REQ_FETCH, 32'h0000_0001, 1'b0);
        write_frame_limit(5'd16);
    endtask

    task automatic test_random_traffic(int n, logic [CFG_W-1:0] lim);
        int sel;
        int pinned[$];
        t_req rq;
        logic [PAGE_W-1:0] pg;
        write_frame_limit(lim);
        foreach (page_set[j])
            page_set[j] = $urandom();
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            pg = page_set[$urandom_range(PAGE_SET_N - 1)];
            if (sel < 45) begin
                rq = REQ_FETCH;
            end else if (sel < 85) begin
                rq = REQ_UNPIN;
                pinned = {};
                for (int f = 0; f < NUM_FRAMES; f++)
                    if (fr_valid[f] && fr_pins[f] != 0)
                        pinned.push_back(f);
                if (pinned.size() > 0 && $urandom_range(9) < 8)
                    pg = fr_page[pinned[$urandom_range(pinned.size() - 1)]];
            end else if (sel < 95) begin
                rq = REQ_FLUSH;
            end else begin
                rq = t_req'($urandom_range(3));
                pg = $urandom();
            end
            send_req(rq, pg, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        wait_for_replies();
        @(posedge clk);
        hold_off = 400;
        for (int k = 0; k < 12; k++) begin
            if (k % 3 == 2)
                send_req(REQ_UNPIN, page_set[k % 4], 1'(k));
            else
                send_req(REQ_FETCH, page_set[k % 4], 1'b0);
        end
        wait_for_replies();
    endtask

    task automatic test_pin_saturation();
        logic [PAGE_W-1:0] pg;
        write_frame_limit(5'd16);
        for (int f = 0; f < NUM_FRAMES; f++)
            while (fr_valid[f] && fr_pins[f] != 0)
                send_req(REQ_UNPIN, fr_page[f], 1'b0);
        pg = $urandom();
        repeat (260) send_req(REQ_FETCH, pg, 1'b0);
        repeat (256) send_req(REQ_UNPIN, pg, 1'($urandom_range(1)));
        send_req(REQ_FLUSH, pg, 1'b0);
    endtask

    task automatic finish_run();
        wait_for_replies();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 11;
        rx_idle_pct = 47;
        test_basic_requests();
        test_frame_limits();
        test_random_traffic(90, 5'd16);
        test_random_traffic(50, 5'd3);
        tx_idle_pct = 47;
        rx_idle_pct = 11;
        test_backpressure();
        test_random_traffic(60, 5'd31);
        test_random_traffic(40, 5'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_pin_saturation();
        test_random_traffic(25, 5'd0);
        test_random_traffic(25, CFG_W'($urandom_range(2, 15)));
        finish_run();
    end
endmodule

// File: sim.f
rtl/lrubp_pkg.sv
rtl/lrubp_frame_table.sv
rtl/lru_buffer_pool_frame_manager.sv
rtl/lrubp_checker.sv
bench/tb.sv
